// File: rtl/core/ptlse_pkg.sv
// Shared types, character codes and helpers of the plain text line and space encoder.
// No dependencies; used by ptlse_mod_unit and plain_text_line_and_space_encoder.
package ptlse_pkg;

    // Field widths
    localparam int CODE_W = 16;
    localparam int TW_W   = 5;
    localparam int EOL_W  = 3;

    // Tab stop limits
    localparam logic [TW_W-1:0] TAB_MIN = 5'd1;
    localparam logic [TW_W-1:0] TAB_MAX = 5'd16;
    localparam logic [TW_W-1:0] TAB_RST = 5'd8;

    // Character codes
    localparam logic [CODE_W-1:0] CH_NUL   = 16'd0;
    localparam logic [CODE_W-1:0] CH_TAB   = 16'd9;
    localparam logic [CODE_W-1:0] CH_LF    = 16'd10;
    localparam logic [CODE_W-1:0] CH_CR    = 16'd13;
    localparam logic [CODE_W-1:0] CH_SPACE = 16'd32;
    localparam logic [CODE_W-1:0] CH_BANG  = 16'd33;
    localparam logic [CODE_W-1:0] CH_DOT   = 16'd46;
    localparam logic [CODE_W-1:0] CH_COLON = 16'd58;
    localparam logic [CODE_W-1:0] CH_SEMI  = 16'd59;
    localparam logic [CODE_W-1:0] CH_QUEST = 16'd63;

    // Break bytes
    localparam logic [CODE_W-1:0] BRK_SOFT = 16'd0;
    localparam logic [CODE_W-1:0] BRK_HARD = 16'd10;

    // Largest bijective base-8 digit
    localparam logic [3:0] DIGIT_MAX = 4'd8;

    // Line end kinds, one bit each
    localparam logic [EOL_W-1:0] EOL_NONE = 3'b000;
    localparam logic [EOL_W-1:0] EOL_NUL  = 3'b001;
    localparam logic [EOL_W-1:0] EOL_LF   = 3'b010;
    localparam logic [EOL_W-1:0] EOL_CR   = 3'b100;

    // Kind bit of a line end code, none for any other code
    function automatic logic [EOL_W-1:0] eol_kind(input logic [CODE_W-1:0] c);
        logic [EOL_W-1:0] k;
        k = EOL_NONE;
        if (c == CH_NUL)
            k = EOL_NUL;
        else if (c == CH_LF)
            k = EOL_LF;
        else if (c == CH_CR)
            k = EOL_CR;
        return k;
    endfunction

    // Sentence ending punctuation
    function automatic logic ends_sentence(input logic [CODE_W-1:0] c);
        return (c == CH_DOT) || (c == CH_BANG) || (c == CH_QUEST) ||
               (c == CH_COLON) || (c == CH_SEMI);
    endfunction

    // One restoring remainder step: bring in one dividend bit, subtract once
    function automatic logic [TW_W-1:0] rem_step(input logic [TW_W-1:0] rem,
                                                 input logic b,
                                                 input logic [TW_W-1:0] div);
        logic [TW_W:0] r;
        r = {rem, b};
        if (r >= {1'b0, div})
            r = r - {1'b0, div};
        return r[TW_W-1:0];
    endfunction

endpackage

// File: rtl/core/ptlse_mod_unit.sv
// Iterative remainder unit: count value modulo tab width, four bits per cycle.
// Depends on ptlse_pkg (rem_step, TW_W).
module ptlse_mod_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [COUNT_BITS-1:0]         dividend,
    input  logic [ptlse_pkg::TW_W-1:0]    divisor,
    output logic                          done,
    output logic [ptlse_pkg::TW_W-1:0]    remainder
);

    localparam int DIG   = (COUNT_BITS + 3) / 4;
    localparam int PAD_W = DIG * 4;
    localparam int CNT_W = $clog2(DIG + 1);

    logic [PAD_W-1:0]              shift_reg;
    logic [ptlse_pkg::TW_W-1:0]    rem_reg;
    logic [ptlse_pkg::TW_W-1:0]    rem_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          done_reg;

    // Four dependent subtract steps, most significant bit first
    always_comb
    begin
        rem_next = rem_reg;
        for (int k = 0; k < 4; k++)
        begin
            rem_next = ptlse_pkg::rem_step(rem_next, shift_reg[PAD_W-1-k], divisor);
        end
    end

    // Digit counter and shift register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            shift_reg <= PAD_W'(dividend);
            rem_reg   <= '0;
            cnt_reg   <= CNT_W'(DIG);
            done_reg  <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            shift_reg <= shift_reg << 4;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_reg - 1'b1;
            done_reg  <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/plain_text_line_and_space_encoder.sv
// Top level of the plain text line and space encoder: sequencer, line state, break queue.
// Depends on ptlse_pkg and ptlse_mod_unit.
//
// One character word in, a byte stream out. Runs of spaces and tabs are held back and sent
// as bijective base-8 digits 1..8 (least significant first) before the next visible
// character; line ends give 0 (soft) or 10 (hard) once a later character, a matching line
// end or end of text settles them. The block takes one word at a time and drops s_tready
// while it works. A space gives no output. A visible character sends one word for each
// settled break, each space digit and the character itself, at most eight in all. A line
// end sends the settled breaks at the head of the queue; end of text sends every queued
// break. A tab takes one run of the shared remainder unit for the column and, for each of
// the three break slots, another run if it holds an undecided break.
// The remainder unit is the one modulo datapath; the output register decouples the sink.
module plain_text_line_and_space_encoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] char_code
    input  logic        s_axis_tuser,   // [0] end_of_text
    // Output words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_code
    output logic        m_axis_tuser,   // [0] out_is_char
    output logic        m_axis_tlast,   // out_last
    // Tab width register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data        // [4:0] tab_width
);

    localparam int CB     = COUNT_BITS;
    localparam int CW     = ptlse_pkg::CODE_W;
    localparam int TW     = ptlse_pkg::TW_W;
    localparam int EW     = ptlse_pkg::EOL_W;
    localparam int SP_W   = (COUNT_BITS < 13) ? COUNT_BITS : 13;
    localparam int unsigned SPACE_MAX_I = (COUNT_BITS >= 13) ? 4680 : ((1 << COUNT_BITS) - 1);
    localparam logic [SP_W-1:0] SPACE_MAX = SP_W'(SPACE_MAX_I);
    localparam int SLOTS  = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN,
        S_LEND,
        S_DIGIT,
        S_CHAR,
        S_TAB_SEL,
        S_TAB_WAIT,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        K_EOT,
        K_LINE,
        K_VIS
    } kind_t;

    // Sequencer
    state_t              state_reg;
    kind_t               kind_reg;
    logic [CW-1:0]       char_reg;
    logic [2:0]          tgt_reg;
    logic [SP_W-1:0]     digit_reg;

    // Line state
    logic [TW-1:0]       tab_width_reg;
    logic [EW-1:0]       eol_flags_reg;
    logic                para_reg;
    logic [CB-1:0]       col_reg;
    logic [SP_W-1:0]     space_run_reg;
    logic [CB-1:0]       new_indent_reg;
    logic [CB-1:0]       least_reg;
    logic [CW-1:0]       prev_vis_reg;

    // Break queue, slot 0 leaves first
    logic                q_pend_reg [SLOTS];
    logic [EW-1:0]       q_kind_reg [SLOTS];
    logic                q_hard_reg [SLOTS];
    logic [CB-1:0]       q_run_reg  [SLOTS];
    logic [1:0]          q_len_reg;

    // Staged word and output register
    logic                stage_valid_reg;
    logic [CW-1:0]       stage_code_reg;
    logic                stage_is_char_reg;
    logic                m_tvalid_reg;
    logic [CW-1:0]       m_code_reg;
    logic                m_is_char_reg;
    logic                m_last_reg;

    // Combinational
    logic [TW-1:0]       tab_eff;
    logic [CW-1:0]       in_code;
    logic [EW-1:0]       in_kind;
    logic [EW-1:0]       cur_kind;
    logic                in_blank;
    logic                sent_hit;
    logic [TW-1:0]       tab_add;
    logic [TW-1:0]       blank_add;
    logic [CB:0]         col_sum;
    logic [CB-1:0]       col_sat;
    logic [CB:0]         ind_sum;
    logic [CB-1:0]       ind_sat;
    logic [SP_W:0]       sp_sum;
    logic [SP_W-1:0]     sp_sat;
    logic [CB:0]         run_sum [SLOTS];
    logic [CB-1:0]       run_sat [SLOTS];
    logic [EW-1:0]       flags_new;
    logic                line_end;
    logic [2:0]          dig_low;
    logic                dig_big;
    logic [3:0]          dig_val;
    logic [SP_W-1:0]     digit_after;
    logic                out_free;
    logic                can_emit;
    logic                emit_req;
    logic                emit_go;
    logic [CW-1:0]       emit_code;
    logic                emit_is_char;
    logic                fin_go;
    logic                tab_need;
    logic [CB-1:0]       mu_dividend;
    logic                mu_start;
    logic                mu_done;
    logic [TW-1:0]       mu_rem;

    // Effective tab width: zero acts as one, above sixteen as sixteen
    always_comb
    begin
        if (tab_width_reg == '0)
            tab_eff = ptlse_pkg::TAB_MIN;
        else if (tab_width_reg > ptlse_pkg::TAB_MAX)
            tab_eff = ptlse_pkg::TAB_MAX;
        else
            tab_eff = tab_width_reg;
    end

    assign in_code  = s_axis_tdata[CW-1:0];
    assign in_kind  = ptlse_pkg::eol_kind(in_code);
    assign cur_kind = ptlse_pkg::eol_kind(char_reg);
    assign in_blank = (in_code == ptlse_pkg::CH_TAB) || (in_code == ptlse_pkg::CH_SPACE);
    assign sent_hit = ptlse_pkg::ends_sentence(prev_vis_reg);

    // Saturating counters, shared by space, tab and visible character
    assign tab_add   = tab_eff - mu_rem;
    assign blank_add = (state_reg == S_TAB_WAIT) ? tab_add : TW'(1);
    assign col_sum   = {1'b0, col_reg} + (CB+1)'(blank_add);
    assign col_sat   = col_sum[CB] ? '1 : col_sum[CB-1:0];
    assign ind_sum   = {1'b0, new_indent_reg} + (CB+1)'(blank_add);
    assign ind_sat   = ind_sum[CB] ? '1 : ind_sum[CB-1:0];
    assign sp_sum    = {1'b0, space_run_reg} + (SP_W+1)'(blank_add);
    assign sp_sat    = (sp_sum > {1'b0, SPACE_MAX}) ? SPACE_MAX : sp_sum[SP_W-1:0];

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            run_sum[i] = {1'b0, q_run_reg[i]} + (CB+1)'(blank_add);
            run_sat[i] = run_sum[i][CB] ? '1 : run_sum[i][CB-1:0];
        end
    end

    // Line end kind tracking; a mismatched kind right after another line end is no break
    always_comb
    begin
        if (eol_flags_reg == ptlse_pkg::EOL_NONE)
        begin
            flags_new = cur_kind;
            line_end  = 1'b1;
        end
        else if ((eol_flags_reg & cur_kind) == ptlse_pkg::EOL_NONE)
        begin
            flags_new = ptlse_pkg::EOL_NONE;
            line_end  = 1'b0;
        end
        else
        begin
            flags_new = eol_flags_reg;
            line_end  = 1'b1;
        end
    end

    // Bijective base-8 digit, least significant first
    assign dig_low     = digit_reg[2:0];
    assign dig_big     = (digit_reg > SP_W'(8));
    assign dig_val     = dig_big ? ((dig_low == 3'd0) ? ptlse_pkg::DIGIT_MAX : {1'b0, dig_low})
                                 : digit_reg[3:0];
    assign digit_after = dig_big ? ((digit_reg >> 3) - SP_W'(dig_low == 3'd0)) : '0;

    // Word production through the stage register
    assign out_free = !m_tvalid_reg || m_axis_tready;
    assign can_emit = !stage_valid_reg || out_free;

    always_comb
    begin
        emit_req     = 1'b0;
        emit_code    = ptlse_pkg::BRK_HARD;
        emit_is_char = 1'b0;
        unique case (state_reg)
            S_DRAIN:
            begin
                emit_req  = (q_len_reg != 2'd0) && !q_pend_reg[0];
                emit_code = q_hard_reg[0] ? ptlse_pkg::BRK_HARD : ptlse_pkg::BRK_SOFT;
            end
            S_LEND:
            begin
                emit_req  = line_end && (col_reg == '0) && (q_len_reg == 2'd0);
                emit_code = ptlse_pkg::BRK_HARD;
            end
            S_DIGIT:
            begin
                emit_req  = (digit_reg != '0);
                emit_code = CW'(dig_val);
            end
            S_CHAR:
            begin
                emit_req     = 1'b1;
                emit_code    = char_reg;
                emit_is_char = 1'b1;
            end
            S_IDLE, S_TAB_SEL, S_TAB_WAIT, S_FIN:
            begin
                emit_req = 1'b0;
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    assign emit_go = emit_req && can_emit;
    assign fin_go  = (state_reg == S_FIN) && stage_valid_reg && out_free;

    // Tab run target: column first, then each waiting break
    always_comb
    begin
        unique case (tgt_reg)
            3'd1:
            begin
                tab_need    = (q_len_reg >= 2'd1) && q_pend_reg[0];
                mu_dividend = q_run_reg[0];
            end
            3'd2:
            begin
                tab_need    = (q_len_reg >= 2'd2) && q_pend_reg[1];
                mu_dividend = q_run_reg[1];
            end
            3'd3:
            begin
                tab_need    = (q_len_reg == 2'd3) && q_pend_reg[2];
                mu_dividend = q_run_reg[2];
            end
            3'd0:
            begin
                tab_need    = 1'b1;
                mu_dividend = col_reg;
            end
            default:
            begin
                tab_need    = 1'b0;
                mu_dividend = col_reg;
            end
        endcase
    end

    assign mu_start = (state_reg == S_TAB_SEL) && tab_need;

    ptlse_mod_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mu_start),
        .dividend  (mu_dividend),
        .divisor   (tab_eff),
        .done      (mu_done),
        .remainder (mu_rem)
    );

    // Sequencer, line state, queue and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            kind_reg          <= K_EOT;
            char_reg          <= '0;
            tgt_reg           <= '0;
            digit_reg         <= '0;
            tab_width_reg     <= ptlse_pkg::TAB_RST;
            eol_flags_reg     <= ptlse_pkg::EOL_NONE;
            para_reg          <= 1'b0;
            col_reg           <= '0;
            space_run_reg     <= '0;
            new_indent_reg    <= '0;
            least_reg         <= '1;
            prev_vis_reg      <= '0;
            q_len_reg         <= 2'd0;
            for (int i = 0; i < SLOTS; i++)
            begin
                q_pend_reg[i] <= 1'b0;
                q_kind_reg[i] <= ptlse_pkg::EOL_NONE;
                q_hard_reg[i] <= 1'b0;
                q_run_reg[i]  <= '0;
            end
            stage_valid_reg   <= 1'b0;
            stage_code_reg    <= '0;
            stage_is_char_reg <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            m_code_reg        <= '0;
            m_is_char_reg     <= 1'b0;
            m_last_reg        <= 1'b0;
        end
        else
        begin
            // Tab width register
            if (cfg_valid)
                tab_width_reg <= cfg_data;

            // Stage register takes each new word
            if (emit_go)
            begin
                stage_valid_reg   <= 1'b1;
                stage_code_reg    <= emit_code;
                stage_is_char_reg <= emit_is_char;
            end
            else if (fin_go)
            begin
                stage_valid_reg <= 1'b0;
            end

            // Output register: staged word moves on when displaced or at the end of a step
            if ((emit_go && stage_valid_reg) || fin_go)
            begin
                m_tvalid_reg  <= 1'b1;
                m_code_reg    <= stage_code_reg;
                m_is_char_reg <= stage_is_char_reg;
                m_last_reg    <= fin_go;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                // Accept a word and do the updates made on acceptance
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        char_reg <= in_code;
                        if (s_axis_tuser)
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (q_pend_reg[i])
                                begin
                                    q_pend_reg[i] <= 1'b0;
                                    q_hard_reg[i] <= 1'b1;
                                end
                            end
                            kind_reg  <= K_EOT;
                            state_reg <= S_DRAIN;
                        end
                        else if (in_kind != ptlse_pkg::EOL_NONE)
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (q_pend_reg[i] && ((q_kind_reg[i] & in_kind) != '0))
                                begin
                                    q_pend_reg[i] <= 1'b0;
                                    q_hard_reg[i] <= 1'b1;
                                end
                            end
                            kind_reg  <= K_LINE;
                            state_reg <= S_DRAIN;
                        end
                        else if (in_blank)
                        begin
                            eol_flags_reg <= ptlse_pkg::EOL_NONE;
                            if (in_code == ptlse_pkg::CH_SPACE)
                            begin
                                for (int i = 0; i < SLOTS; i++)
                                begin
                                    if (q_pend_reg[i])
                                        q_run_reg[i] <= run_sat[i];
                                end
                                col_reg       <= col_sat;
                                space_run_reg <= sp_sat;
                                if (para_reg)
                                    new_indent_reg <= ind_sat;
                            end
                            else
                            begin
                                tgt_reg   <= 3'd0;
                                state_reg <= S_TAB_SEL;
                            end
                        end
                        else
                        begin
                            // Visible character settles every waiting break
                            eol_flags_reg <= ptlse_pkg::EOL_NONE;
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (q_pend_reg[i])
                                begin
                                    q_pend_reg[i] <= 1'b0;
                                    q_hard_reg[i] <= (q_run_reg[i] > least_reg) && sent_hit;
                                end
                            end
                            if (para_reg)
                            begin
                                para_reg <= 1'b0;
                                if (new_indent_reg < least_reg)
                                    least_reg <= new_indent_reg;
                            end
                            digit_reg     <= space_run_reg;
                            space_run_reg <= '0;
                            prev_vis_reg  <= in_code;
                            col_reg       <= col_sat;
                            kind_reg      <= K_VIS;
                            state_reg     <= S_DRAIN;
                        end
                    end
                end

                // Send settled breaks from the head of the queue
                S_DRAIN:
                begin
                    if (emit_req)
                    begin
                        if (can_emit)
                        begin
                            for (int i = 0; i < SLOTS - 1; i++)
                            begin
                                q_pend_reg[i] <= q_pend_reg[i+1];
                                q_kind_reg[i] <= q_kind_reg[i+1];
                                q_hard_reg[i] <= q_hard_reg[i+1];
                                q_run_reg[i]  <= q_run_reg[i+1];
                            end
                            q_len_reg <= q_len_reg - 2'd1;
                        end
                    end
                    else
                    begin
                        unique case (kind_reg)
                            K_LINE:  state_reg <= S_LEND;
                            K_VIS:   state_reg <= S_DIGIT;
                            K_EOT:   state_reg <= S_FIN;
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end

                // Line end: direct hard break, or a new queued break
                S_LEND:
                begin
                    if (can_emit)
                    begin
                        eol_flags_reg <= flags_new;
                        if (line_end)
                        begin
                            if (((col_reg != '0) || (q_len_reg != 2'd0)) &&
                                (q_len_reg != 2'(SLOTS)))
                            begin
                                q_pend_reg[q_len_reg] <= (col_reg != '0);
                                q_kind_reg[q_len_reg] <= (col_reg != '0) ? flags_new
                                                                          : ptlse_pkg::EOL_NONE;
                                q_hard_reg[q_len_reg] <= (col_reg == '0);
                                q_run_reg[q_len_reg]  <= '0;
                                q_len_reg             <= q_len_reg + 2'd1;
                            end
                            space_run_reg  <= '0;
                            new_indent_reg <= '0;
                            para_reg       <= 1'b1;
                            col_reg        <= '0;
                        end
                        state_reg <= S_FIN;
                    end
                end

                // Space run digits
                S_DIGIT:
                begin
                    if (!emit_req)
                        state_reg <= S_CHAR;
                    else if (can_emit)
                        digit_reg <= digit_after;
                end

                // Copied character
                S_CHAR:
                begin
                    if (can_emit)
                        state_reg <= S_FIN;
                end

                // Pick the next tab run to advance
                S_TAB_SEL:
                begin
                    if (tgt_reg == 3'd4)
                        state_reg <= S_FIN;
                    else if (tab_need)
                        state_reg <= S_TAB_WAIT;
                    else
                        tgt_reg <= tgt_reg + 3'd1;
                end

                // Advance the run to the next tab stop
                S_TAB_WAIT:
                begin
                    if (mu_done)
                    begin
                        if (tgt_reg == 3'd0)
                        begin
                            col_reg       <= col_sat;
                            space_run_reg <= sp_sat;
                            if (para_reg)
                                new_indent_reg <= ind_sat;
                        end
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (tgt_reg == 3'(i + 1))
                                q_run_reg[i] <= run_sat[i];
                        end
                        tgt_reg   <= tgt_reg + 3'd1;
                        state_reg <= S_TAB_SEL;
                    end
                end

                // Close the step with the last word
                S_FIN:
                begin
                    if (!stage_valid_reg || out_free)
                        state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_code_reg;
    assign m_axis_tuser  = m_is_char_reg;
    assign m_axis_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // No staged word is left behind when a new input word is taken
    a_idle_stage_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !stage_valid_reg)
        else $error("stage word pending while accepting input");

    // Remainder results only arrive while a tab run waits for them
    a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mu_done |-> (state_reg == S_TAB_WAIT))
        else $error("remainder unit finished outside tab wait");

    // Space digits are always 1..8
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIGIT && emit_go) |-> (emit_code != 16'd0 && emit_code <= 16'd8))
        else $error("space digit out of range");

    // Each break sent from the queue removes exactly one slot
    a_drain_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && emit_go) |=> (q_len_reg == $past(q_len_reg) - 2'd1))
        else $error("break queue length did not drop on send");
`endif

endmodule
